// ===== src/fpbt_pkg.sv =====
package fpbt_pkg;

  // Widths of the configuration port.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_ZERO = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_ONE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE     = 4'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] HALF_ZERO_RST = 16'(887 / 2);
  localparam logic [15:0] HALF_ONE_RST  = 16'(694 / 2);
  localparam logic [15:0] BURST_RST     = 16'd100;
  localparam logic [15:0] PAUSE_RST     = 16'd9900;

  // Number of bits in one transmitted byte.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Transmitter phase.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BURST = 2'd1,
    PH_PAUSE = 2'd2
  } phase_t;

  // Configuration registers as seen by the transmit core.
  typedef struct packed {
    logic [15:0] half_period_zero;
    logic [15:0] half_period_one;
    logic [15:0] burst_ticks;
    logic [15:0] pause_ticks;
  } cfg_t;

  // One input request.
  typedef struct packed {
    logic       start_req;
    logic [7:0] data_byte;
    logic       tick;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic       drive_hi;
    logic       drive_lo;
    logic       busy_res;
    logic [3:0] bit_number;
    logic       done_res;
  } out_item_t;

endpackage

// ===== src/fpbt_if.sv =====
// Input channel: one request per timer clock cycle.
interface fpbt_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] data_byte;
  logic       tick;

  modport source (output valid, output start_req, output data_byte, output tick,
                  input ready);
  modport sink   (input valid, input start_req, input data_byte, input tick,
                  output ready);
endinterface

// Result channel: drive outputs and status for one request.
interface fpbt_out_if;
  logic       valid;
  logic       ready;
  logic       drive_hi;
  logic       drive_lo;
  logic       busy_res;
  logic [3:0] bit_number;
  logic       done_res;

  modport source (output valid, output drive_hi, output drive_lo, output busy_res,
                  output bit_number, output done_res, input ready);
  modport sink   (input valid, input drive_hi, input drive_lo, input busy_res,
                  input bit_number, input done_res, output ready);
endinterface

// ===== src/fsk_ping_byte_transmitter.sv =====
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    start_req, data_byte[7:0], tick
// out_ch    out  valid/ready    drive_hi, drive_lo, busy_res, bit_number[3:0], done_res
// cfg_*     in   write enable   cfg_index[3:0], cfg_data[15:0]
//
// Each request advances the transmit state once; its result sits in the output
// register in the cycle after acceptance, and while out_ch does not stall a request
// can be accepted in every cycle. The throughput is then one request per cycle, set by
// the single state update between the transmit state registers and the output register.
// Reset (rst_n low, synchronous) returns to idle with the default tone and
// timing registers. When out_ch stalls, in_ch.ready drops until the held
// result is taken, so no result is lost.
module fsk_ping_byte_transmitter
  import fpbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  fpbt_in_if.sink               in_ch,
  fpbt_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  item;
  out_item_t result;
  out_item_t held;
  logic      full;
  logic      in_fire;

  // Accept while the output register is empty or being emptied this cycle.
  assign in_ch.ready = !full || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign item.start_req = in_ch.start_req;
  assign item.data_byte = in_ch.data_byte;
  assign item.tick      = in_ch.tick;

  fpbt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpbt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_fire),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  fpbt_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_fire),
    .result (result),
    .take   (out_ch.ready),
    .full   (full),
    .held   (held)
  );

  assign out_ch.valid      = full;
  assign out_ch.drive_hi   = held.drive_hi;
  assign out_ch.drive_lo   = held.drive_lo;
  assign out_ch.busy_res   = held.busy_res;
  assign out_ch.bit_number = held.bit_number;
  assign out_ch.done_res   = held.done_res;

  // An accepted request always leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_ch.valid)
    else $error("accepted request produced no result");

  // A stalled result blocks new requests.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted over a stalled result");

  // The drives are never both high, and are only active while busy.
  a_drive_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.drive_hi || out_ch.drive_lo)) |->
      (!(out_ch.drive_hi && out_ch.drive_lo) && out_ch.busy_res))
    else $error("drive outputs inconsistent with transmit state");

endmodule

// ===== src/fpbt_cfg_regs.sv =====
module fpbt_cfg_regs
  import fpbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Register file; writes beyond the last index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_zero <= HALF_ZERO_RST;
      cfg_r.half_period_one  <= HALF_ONE_RST;
      cfg_r.burst_ticks      <= BURST_RST;
      cfg_r.pause_ticks      <= PAUSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_ZERO: cfg_r.half_period_zero <= cfg_data;
        CFG_HALF_ONE:  cfg_r.half_period_one  <= cfg_data;
        CFG_BURST:     cfg_r.burst_ticks      <= cfg_data;
        CFG_PAUSE:     cfg_r.pause_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/fpbt_core.sv =====
module fpbt_core
  import fpbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  phase_t      phase_r,    phase_nxt;
  logic [15:0] tone_cnt_r, tone_cnt_nxt;
  logic [15:0] ticks_r,    ticks_nxt;
  logic [7:0]  shift_r,    shift_nxt;
  logic [3:0]  bits_r,     bits_nxt;
  logic        hi_r,       hi_nxt;
  logic        lo_r,       lo_nxt;
  logic        done;

  logic [15:0] cmp;
  logic [15:0] ticks_dec;
  logic        phase_end;

  // The tone compare follows the current bit; the tick count ends the phase at zero.
  assign cmp       = shift_r[7] ? cfg.half_period_one : cfg.half_period_zero;
  assign ticks_dec = (item.tick && (ticks_r != 16'd0)) ? ticks_r - 16'd1 : ticks_r;
  assign phase_end = (ticks_dec == 16'd0);

  // Next state for one timer cycle.
  always_comb begin
    phase_nxt    = phase_r;
    tone_cnt_nxt = tone_cnt_r;
    ticks_nxt    = ticks_r;
    shift_nxt    = shift_r;
    bits_nxt     = bits_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    done         = 1'b0;
    unique case (phase_r)
      PH_BURST: begin
        if (tone_cnt_r == cmp) begin
          tone_cnt_nxt = 16'd0;
          hi_nxt       = ~hi_r;
          lo_nxt       = ~lo_r;
        end else begin
          tone_cnt_nxt = tone_cnt_r + 16'd1;
        end
        if (phase_end) begin
          phase_nxt = PH_PAUSE;
          ticks_nxt = cfg.pause_ticks;
          hi_nxt    = 1'b0;
          lo_nxt    = 1'b0;
        end else begin
          ticks_nxt = ticks_dec;
        end
      end
      PH_PAUSE: begin
        ticks_nxt = ticks_dec;
        if (phase_end) begin
          if (bits_r >= BITS_PER_BYTE) begin
            phase_nxt = PH_IDLE;
            bits_nxt  = 4'd0;
            ticks_nxt = 16'd0;
            done      = 1'b1;
          end else begin
            bits_nxt     = bits_r + 4'd1;
            shift_nxt    = {shift_r[6:0], 1'b0};
            phase_nxt    = PH_BURST;
            ticks_nxt    = cfg.burst_ticks;
            tone_cnt_nxt = 16'd0;
            hi_nxt       = 1'b1;
            lo_nxt       = 1'b0;
          end
        end
      end
      default: begin
        // Idle, and the unused phase code, which behaves the same.
        phase_nxt = PH_IDLE;
        hi_nxt    = 1'b0;
        lo_nxt    = 1'b0;
        if (item.start_req) begin
          shift_nxt    = item.data_byte;
          bits_nxt     = 4'd1;
          phase_nxt    = PH_BURST;
          ticks_nxt    = cfg.burst_ticks;
          tone_cnt_nxt = 16'd0;
          hi_nxt       = 1'b1;
          lo_nxt       = 1'b0;
        end
      end
    endcase
  end

  // Result of this cycle, taken from the updated state.
  always_comb begin
    result.drive_hi   = hi_nxt;
    result.drive_lo   = lo_nxt;
    result.busy_res   = (phase_nxt != PH_IDLE);
    result.bit_number = (phase_nxt != PH_IDLE) ? bits_nxt : 4'd0;
    result.done_res   = done;
  end

  // State registers advance once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tone_cnt_r <= 16'd0;
      ticks_r    <= 16'd0;
      shift_r    <= 8'd0;
      bits_r     <= 4'd0;
      hi_r       <= 1'b0;
      lo_r       <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tone_cnt_r <= tone_cnt_nxt;
      ticks_r    <= ticks_nxt;
      shift_r    <= shift_nxt;
      bits_r     <= bits_nxt;
      hi_r       <= hi_nxt;
      lo_r       <= lo_nxt;
    end
  end

endmodule

// ===== src/fpbt_out_reg.sv =====
module fpbt_out_reg
  import fpbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t result,
  input  logic      take,
  output logic      full,
  output out_item_t held
);

  logic      valid_r;
  out_item_t item_r;

  // Valid flag: set by a new result, cleared when the held one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result;
    end
  end

  assign full = valid_r;
  assign held = item_r;

endmodule

// ===== verif/fsk_ping_byte_transmitter_tb.sv =====
module fsk_ping_byte_transmitter_tb;
  import fpbt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned LONG_HOLD   = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fpbt_in_if  in_ch();
  fpbt_out_if out_ch();

  fsk_ping_byte_transmitter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(5ns) clk = ~clk;

  // Requests waiting to be offered and drive results waiting to be seen.
  in_item_t  ping_req_q[$];
  out_item_t drive_exp_q[$];
  int unsigned req_queued = 0;
  int unsigned req_taken = 0;
  int unsigned err_cnt = 0;
  int unsigned tick_pct = 50;
  bit hold_req = 1'b0;

  // Transmitter state as the testbench tracks it.
  cfg_t        tx_cfg;
  phase_t      tx_phase;
  logic [15:0] tone_cnt;
  logic [15:0] ticks_rem;
  logic [7:0]  shift_q;
  logic [3:0]  bit_idx;
  logic        drv_hi;
  logic        drv_lo;

  // Sender and receiver pacing.
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_cnt;
  logic [8:0]  rx_cyc;
  int unsigned quiet_cycles;
  in_item_t    req_now;
  out_item_t   res_now;
  out_item_t   want;

  task automatic begin_burst();
    tx_phase = PH_BURST;
    ticks_rem = tx_cfg.burst_ticks;
    tone_cnt = '0;
    drv_hi = 1'b1;
    drv_lo = 1'b0;
  endtask

  // Counts one timebase tick; returns 1 once the current phase has run out.
  function automatic logic tick_expired(input logic tick);
    if (tick && ticks_rem != 16'd0) ticks_rem = ticks_rem - 16'd1;
    return ticks_rem == 16'd0;
  endfunction

  // Advances the transmitter by one timer cycle and forms the drive result.
  task automatic step_transmitter(input in_item_t req, output out_item_t res);
    logic [15:0] cmp;
    logic        done;
    done = 1'b0;
    case (tx_phase)
      PH_BURST: begin
        cmp = shift_q[7] ? tx_cfg.half_period_one : tx_cfg.half_period_zero;
        if (tone_cnt == cmp) begin
          tone_cnt = '0;
          drv_hi = ~drv_hi;
          drv_lo = ~drv_lo;
        end else begin
          tone_cnt = tone_cnt + 16'd1;
        end
        if (tick_expired(req.tick)) begin
          tx_phase = PH_PAUSE;
          ticks_rem = tx_cfg.pause_ticks;
          drv_hi = 1'b0;
          drv_lo = 1'b0;
        end
      end
      PH_PAUSE: begin
        if (tick_expired(req.tick)) begin
          if (bit_idx >= BITS_PER_BYTE) begin
            tx_phase = PH_IDLE;
            bit_idx = '0;
            ticks_rem = '0;
            done = 1'b1;
          end else begin
            bit_idx = bit_idx + 4'd1;
            shift_q = {shift_q[6:0], 1'b0};
            begin_burst();
          end
        end
      end
      default: begin
        tx_phase = PH_IDLE;
        drv_hi = 1'b0;
        drv_lo = 1'b0;
        if (req.start_req) begin
          shift_q = req.data_byte;
          bit_idx = 4'd1;
          begin_burst();
        end
      end
    endcase
    res.drive_hi = drv_hi;
    res.drive_lo = drv_lo;
    res.busy_res = (tx_phase != PH_IDLE);
    res.bit_number = (tx_phase != PH_IDLE) ? bit_idx : 4'd0;
    res.done_res = done;
  endtask

  function automatic logic rand_tick();
    return $urandom_range(99) < tick_pct;
  endfunction

  // Byte values lean toward the extremes and the single-bit patterns.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_req(input logic start, input logic [7:0] data, input logic tick);
    in_item_t req;
    req.start_req = start;
    req.data_byte = data;
    req.tick = tick;
    ping_req_q.push_back(req);
    req_queued++;
  endtask

  // Register writes happen only while the transmitter is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HALF_ZERO: tx_cfg.half_period_zero = val;
      CFG_HALF_ONE:  tx_cfg.half_period_one = val;
      CFG_BURST:     tx_cfg.burst_ticks = val;
      CFG_PAUSE:     tx_cfg.pause_ticks = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] hz, input logic [15:0] ho,
                           input logic [15:0] bt, input logic [15:0] pt);
    write_reg(CFG_HALF_ZERO, hz);
    write_reg(CFG_HALF_ONE, ho);
    write_reg(CFG_BURST, bt);
    write_reg(CFG_PAUSE, pt);
  endtask

  // Keeps feeding quiet requests until the byte in progress has finished.
  task automatic drain_to_idle();
    wait (req_taken == req_queued);
    while (tx_phase != PH_IDLE) begin
      repeat (16) queue_req(1'b0, 8'($urandom), rand_tick());
      wait (req_taken == req_queued);
    end
    wait (drive_exp_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic flag_field(input string name, input logic [3:0] exp_v,
                            input logic [3:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // Request driver: offers queued requests in bursts separated by gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        req_now.start_req = in_ch.start_req;
        req_now.data_byte = in_ch.data_byte;
        req_now.tick = in_ch.tick;
        step_transmitter(req_now, res_now);
        drive_exp_q.push_back(res_now);
        req_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || ping_req_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          req_now = ping_req_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.start_req <= req_now.start_req;
          in_ch.data_byte <= req_now.data_byte;
          in_ch.tick <= req_now.tick;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            gap_left = $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // Result receiver: cycles through stall patterns, with one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cyc <= '0;
      hold_cnt = 0;
    end else begin
      rx_cyc <= rx_cyc + 9'd1;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_cyc[8:7])
          2'd0: out_ch.ready <= 1'b1;
          2'd1: out_ch.ready <= (rx_cyc[1:0] != 2'd0);
          2'd2: out_ch.ready <= 1'($urandom_range(1));
          default: out_ch.ready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // Result checker: compares every taken result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_exp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b %b %b %h %b", $time,
                 out_ch.drive_hi, out_ch.drive_lo, out_ch.busy_res, out_ch.bit_number,
                 out_ch.done_res);
        err_cnt++;
      end else begin
        want = drive_exp_q.pop_front();
        flag_field("drive_hi", 4'(want.drive_hi), 4'(out_ch.drive_hi));
        flag_field("drive_lo", 4'(want.drive_lo), 4'(out_ch.drive_lo));
        flag_field("busy_res", 4'(want.busy_res), 4'(out_ch.busy_res));
        flag_field("bit_number", want.bit_number, out_ch.bit_number);
        flag_field("done_res", 4'(want.done_res), 4'(out_ch.done_res));
      end
    end
  end

  // Watchdog: ends the run when no handshake completes for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [15:0] hz;
    logic [15:0] ho;
    logic [15:0] bt;
    logic [15:0] pt;
    int unsigned fill;
    int unsigned gap;

    in_ch.valid = 1'b0;
    in_ch.start_req = 1'b0;
    in_ch.data_byte = '0;
    in_ch.tick = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    tx_cfg.half_period_zero = HALF_ZERO_RST;
    tx_cfg.half_period_one = HALF_ONE_RST;
    tx_cfg.burst_ticks = BURST_RST;
    tx_cfg.pause_ticks = PAUSE_RST;
    tx_phase = PH_IDLE;
    tone_cnt = '0;
    ticks_rem = '0;
    shift_q = '0;
    bit_idx = '0;
    drv_hi = 1'b0;
    drv_lo = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Idle after reset, then one byte on the reset tones and burst length.
    tick_pct = 50;
    repeat (4) queue_req(1'b0, 8'($urandom), rand_tick());
    drain_to_idle();
    write_reg(CFG_PAUSE, 16'd0);
    tick_pct = 100;
    queue_req(1'b1, 8'h0F, rand_tick());
    drain_to_idle();

    // Zero-length bursts and pauses: starts while busy and in the done cycle
    // are ignored, and the next start right after it is taken.
    write_all(16'd0, 16'd0, 16'd0, 16'd0);
    tick_pct = 50;
    queue_req(1'b1, 8'hA5, rand_tick());
    repeat (15) queue_req(1'b1, 8'($urandom), rand_tick());
    queue_req(1'b1, 8'h3C, rand_tick());
    queue_req(1'b1, 8'hFF, rand_tick());
    drain_to_idle();

    // Random bytes over several settings, the tone extremes among them.
    for (int p = 0; p < 8; p++) begin
      hz = 16'($urandom_range(0, 12));
      ho = 16'($urandom_range(0, 12));
      bt = 16'($urandom_range(0, 6));
      pt = 16'($urandom_range(0, 6));
      if (p == 2) begin
        hz = 16'd0;
        ho = 16'hFFFF;
      end else if (p == 5) begin
        hz = 16'hFFFF;
        ho = 16'd0;
      end
      tick_pct = $urandom_range(40, 100);
      write_all(hz, ho, bt, pt);
      fill = 0;
      while (fill < 60) begin
        queue_req(1'b1, pick_byte(), rand_tick());
        gap = $urandom_range(0, 20);
        repeat (gap) queue_req($urandom_range(3) == 0, 8'($urandom), rand_tick());
        fill += gap + 1;
      end
      // Hold the receiver off while requests keep coming, so the input stalls.
      if (p == 3) hold_req = 1'b1;
      drain_to_idle();
    end

    // Longest burst and pause: the byte is still in progress when the run ends.
    tick_pct = 100;
    write_all(16'd3, 16'd5, 16'hFFFF, 16'hFFFF);
    queue_req(1'b1, pick_byte(), 1'b1);
    repeat (120) queue_req(1'($urandom_range(1)), 8'($urandom), rand_tick());

    wait (req_taken == req_queued);
    wait (drive_exp_q.size() == 0);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== fsk_ping_byte_transmitter.f =====
src/fpbt_pkg.sv
src/fpbt_if.sv
src/fpbt_cfg_regs.sv
src/fpbt_core.sv
src/fpbt_out_reg.sv
src/fsk_ping_byte_transmitter.sv
verif/fsk_ping_byte_transmitter_tb.sv
